### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent checks on clocked signals.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check under reset qualification
`define DWV_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// check that also holds while reset is applied
`define DWV_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

### rtl/dwv_pkg.sv
// ---------------------------------------------------------------------------
// Dual wheel velocity PID package
// Constants, register codes, shared structs and helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dwv_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int SAMPLE_RATE_HZ = 500;
    localparam int MAX_WINDOW_DEF = 64;
    localparam int DIV_W          = 42;
    localparam int DIVR_W         = 16;
    localparam int REG_IDX_W      = 3;
    localparam int REG_DATA_W     = 24;

    localparam logic [18:0] TWO_PI_FX = 19'd411775;
    localparam logic [18:0] PI_FX     = 19'd205887;
    localparam logic [8:0]  RATE_K    = 9'(SAMPLE_RATE_HZ);
    localparam logic signed [17:0] ONE_FX = 18'sd65536;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN_P        = 3'd0,
        REG_GAIN_I        = 3'd1,
        REG_GAIN_D        = 3'd2,
        REG_SLEW_LIMIT    = 3'd3,
        REG_WINDOW        = 3'd4,
        REG_TICKS         = 3'd5,
        REG_LEFT_REVERSE  = 3'd6,
        REG_RIGHT_REVERSE = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [23:0] gain_p;
        logic signed [23:0] gain_i;
        logic signed [23:0] gain_d;
        logic [16:0]        slew;
        logic [DIVR_W-1:0]  n;
        logic [DIVR_W-1:0]  ticks;
    } lane_cfg_t;

    typedef struct packed {
        logic               go;
        logic               clear;
        logic               reverse;
        logic signed [31:0] tvel;
        logic signed [31:0] tacc;
    } lane_cmd_t;

    typedef struct packed {
        logic               done;
        logic signed [17:0] drive;
        logic [18:0]        angle;
        logic signed [31:0] speed;
    } lane_res_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

### rtl/dwv_ifs.sv
// ---------------------------------------------------------------------------
// Dual wheel velocity PID channels
// Valid/ready channels for encoder items and control results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dwv_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] count_left;
    logic signed [31:0] count_right;
    logic signed [31:0] target_vel_left;
    logic signed [31:0] target_vel_right;
    logic signed [31:0] target_acc_left;
    logic signed [31:0] target_acc_right;
    logic               clear_terms;

    modport source (output valid, count_left, count_right, target_vel_left,
                    target_vel_right, target_acc_left, target_acc_right,
                    clear_terms, input ready);
    modport sink   (input valid, count_left, count_right, target_vel_left,
                    target_vel_right, target_acc_left, target_acc_right,
                    clear_terms, output ready);
endinterface

interface dwv_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] drive_left;
    logic signed [17:0] drive_right;
    logic [18:0]        angle_left;
    logic [18:0]        angle_right;
    logic signed [31:0] speed_left;
    logic signed [31:0] speed_right;

    modport source (output valid, drive_left, drive_right, angle_left, angle_right,
                    speed_left, speed_right, input ready);
    modport sink   (input valid, drive_left, drive_right, angle_left, angle_right,
                    speed_left, speed_right, output ready);
endinterface

### rtl/dwv_div.sv
// ---------------------------------------------------------------------------
// Iterative divider
// Unsigned restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwv_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dwv_pkg::DIV_W-1:0]  dividend,
    input  logic [dwv_pkg::DIVR_W-1:0] divisor,
    output logic                       done,
    output logic [dwv_pkg::DIV_W-1:0]  quot,
    output logic [dwv_pkg::DIVR_W-1:0] rem
);
    import dwv_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  quot_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVR_W:0]   trial;
    logic              fits;

    always_comb
    begin
        trial = {rem_reg, quot_reg[DIV_W-1]};
        fits  = trial >= {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DIV_W-2:0], fits};
            rem_reg  <= fits ? DIVR_W'(trial - {1'b0, div_reg}) : trial[DIVR_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

### rtl/dwv_lane.sv
// ---------------------------------------------------------------------------
// Wheel control lane
// Window average, angle, rates and PID duty for one wheel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwv_lane #(
    parameter int SUM_W = 39
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dwv_pkg::lane_cmd_t      cmd,
    input  dwv_pkg::lane_cfg_t      cfg,
    input  logic signed [SUM_W-1:0] sum,
    output dwv_pkg::lane_res_t      res
);
    import dwv_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_AVG  = 14'b00000000000010,
        ST_MOD  = 14'b00000000000100,
        ST_ANG  = 14'b00000000001000,
        ST_DIFF = 14'b00000000010000,
        ST_VEL  = 14'b00000000100000,
        ST_DACC = 14'b00000001000000,
        ST_ACC  = 14'b00000010000000,
        ST_ERR  = 14'b00000100000000,
        ST_MP   = 14'b00001000000000,
        ST_MI   = 14'b00010000000000,
        ST_MD   = 14'b00100000000000,
        ST_SUM  = 14'b01000000000000,
        ST_OUT  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIVR_W-1:0]  div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_quot;
    logic [DIVR_W-1:0]  div_rem;

    logic               neg_reg, neg_next;
    logic               clear_reg;
    logic               reverse_reg;
    logic [18:0]        ang_reg;
    logic signed [31:0] speed_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] err_reg;
    logic signed [31:0] derr_reg;
    logic signed [55:0] prod_reg;
    logic signed [57:0] sum_reg;
    logic [18:0]        prior_angle_reg;
    logic signed [31:0] prior_speed_reg;
    logic signed [31:0] integ_reg;
    logic signed [17:0] prior_drive_reg;
    logic               done_reg;
    logic signed [17:0] drive_reg;

    logic [SUM_W-1:0]   sum_mag;
    logic [DIVR_W-1:0]  avg;
    logic signed [19:0] diff;
    logic signed [29:0] vprod;
    logic signed [32:0] dv;
    logic signed [41:0] aprod;
    logic signed [DIV_W:0] qs;
    logic signed [31:0] qsat;
    logic signed [31:0] err;
    logic signed [31:0] integ_base;
    logic signed [41:0] shifted;
    logic signed [18:0] duty;
    logic signed [18:0] delta;
    logic signed [18:0] slew;
    logic signed [18:0] drive_new;

    dwv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_comb
    begin
        sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        avg = (neg_reg && div_rem != '0) ? DIVR_W'(cfg.ticks - div_rem) : div_rem;
        diff = $signed({1'b0, ang_reg}) - $signed({1'b0, prior_angle_reg});
        if (diff < -$signed({1'b0, PI_FX}))
            diff = diff + $signed({1'b0, TWO_PI_FX});
        else if (diff > $signed({1'b0, PI_FX}))
            diff = diff - $signed({1'b0, TWO_PI_FX});
        vprod = diff * $signed({1'b0, RATE_K});
        dv = 33'(speed_reg) - 33'(prior_speed_reg);
        aprod = dv * $signed({1'b0, RATE_K});
        qs = neg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        qsat = sat32(64'(qs));
        err = sat32(64'(cmd.tvel) - 64'(speed_reg));
        integ_base = clear_reg ? 32'sd0 : integ_reg;
        shifted = 42'(sum_reg >>> FRAC_BITS);
        if (shifted > 42'(ONE_FX))
            duty = 19'(ONE_FX);
        else if (shifted < -42'(ONE_FX))
            duty = -19'(ONE_FX);
        else
            duty = 19'(shifted);
        if (reverse_reg)
            duty = -duty;
        slew = $signed({2'b00, cfg.slew});
        delta = duty - 19'(prior_drive_reg);
        if (delta > slew)
            drive_new = 19'(prior_drive_reg) + slew;
        else if (delta < -slew)
            drive_new = 19'(prior_drive_reg) - slew;
        else
            drive_new = duty;
    end

    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = cfg.n;
        neg_next     = neg_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.go)
                begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(sum_mag);
                    neg_next     = sum[SUM_W-1];
                    state_next   = ST_AVG;
                end
            end
            ST_AVG:
            begin
                if (div_done)
                begin
                    div_start    = 1'b1;
                    div_dividend = div_quot;
                    div_divisor  = cfg.ticks;
                    state_next   = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (div_done)
                begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(avg) * DIV_W'(TWO_PI_FX);
                    div_divisor  = cfg.ticks;
                    state_next   = ST_ANG;
                end
            end
            ST_ANG:
            begin
                if (div_done)
                    state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(vprod[29] ? -vprod : vprod);
                neg_next     = vprod[29];
                state_next   = ST_VEL;
            end
            ST_VEL:
            begin
                if (div_done)
                    state_next = ST_DACC;
            end
            ST_DACC:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(aprod[41] ? -aprod : aprod);
                neg_next     = aprod[41];
                state_next   = ST_ACC;
            end
            ST_ACC:
            begin
                if (div_done)
                    state_next = ST_ERR;
            end
            ST_ERR:  state_next = ST_MP;
            ST_MP:   state_next = ST_MI;
            ST_MI:   state_next = ST_MD;
            ST_MD:   state_next = ST_SUM;
            ST_SUM:  state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            done_reg        <= 1'b0;
            prior_angle_reg <= '0;
            prior_speed_reg <= '0;
            integ_reg       <= '0;
            prior_drive_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_OUT);
            if (state_reg == ST_ERR)
                integ_reg <= sat32(64'(integ_base) + 64'(err));
            if (state_reg == ST_OUT)
            begin
                prior_drive_reg <= 18'(drive_new);
                prior_angle_reg <= ang_reg;
                prior_speed_reg <= speed_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        if (state_reg == ST_IDLE && cmd.go)
        begin
            clear_reg   <= cmd.clear;
            reverse_reg <= cmd.reverse;
        end
        if (state_reg == ST_ANG && div_done)
            ang_reg <= div_quot[18:0];
        if (state_reg == ST_VEL && div_done)
            speed_reg <= qsat;
        if (state_reg == ST_ACC && div_done)
            acc_reg <= qsat;
        if (state_reg == ST_ERR)
        begin
            err_reg  <= err;
            derr_reg <= sat32(64'(cmd.tacc) - 64'(acc_reg));
        end
        case (state_reg)
            ST_MP:
            begin
                prod_reg <= cfg.gain_p * err_reg;
            end
            ST_MI:
            begin
                sum_reg  <= 58'(prod_reg);
                prod_reg <= cfg.gain_i * integ_reg;
            end
            ST_MD:
            begin
                sum_reg  <= sum_reg + 58'(prod_reg);
                prod_reg <= cfg.gain_d * derr_reg;
            end
            ST_SUM:
            begin
                sum_reg <= sum_reg + 58'(prod_reg);
            end
            default:
            begin
            end
        endcase
        if (state_reg == ST_OUT)
            drive_reg <= 18'(drive_new);
    end

    assign res.done  = done_reg;
    assign res.drive = drive_reg;
    assign res.angle = prior_angle_reg;
    assign res.speed = prior_speed_reg;

endmodule

### rtl/dual_wheel_velocity_pid_top.sv
// Result path: the accepted item that closes a window starts five serial divisions
// in every wheel lane, and the result turns valid once both lanes complete them.
// Throughput: items inside a window are taken one per cycle; the closing item
// blocks new items until both lanes finish and the result register frees.
// Reset: asynchronous, active low; clears sums, history, integrals and
// duties, and loads the register defaults.
// ---------------------------------------------------------------------------
// Dual wheel velocity PID top level
// Window accumulation, two wheel lanes and the result merge register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_wheel_velocity_pid_top #(
    parameter int MAX_WINDOW = dwv_pkg::MAX_WINDOW_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [dwv_pkg::REG_IDX_W-1:0]  wr_index,
    input  logic [dwv_pkg::REG_DATA_W-1:0] wr_data,
    dwv_in_if.sink                         in_ch,
    dwv_out_if.source                      out_ch
);
    import dwv_pkg::*;

    localparam int SUM_W = 33 + $clog2(MAX_WINDOW);
    localparam int N_W   = $clog2(MAX_WINDOW + 1);

    logic signed [23:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [16:0]        slew_reg;
    logic [6:0]         window_reg;
    logic [15:0]        ticks_reg;
    logic               left_rev_reg, right_rev_reg;

    logic signed [SUM_W-1:0] sum_l_reg, sum_r_reg, sum_l_next, sum_r_next;
    logic [N_W-1:0]     idx_reg;
    logic               clear_pend_reg;
    logic               busy_reg;
    logic               go_reg;
    logic               done_l_reg, done_r_reg;
    logic signed [31:0] tvel_l_reg, tvel_r_reg, tacc_l_reg, tacc_r_reg;
    logic               out_valid_reg;
    logic signed [17:0] drive_l_reg, drive_r_reg;
    logic [18:0]        angle_l_reg, angle_r_reg;
    logic signed [31:0] speed_l_reg, speed_r_reg;

    logic [31:0]        n_wide;
    logic [N_W-1:0]     n_eff;
    logic               accept;
    logic               win_end;
    logic               merge;
    lane_cfg_t          cfg;
    lane_cmd_t          cmd_l, cmd_r;
    lane_res_t          res_l, res_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= 24'sd65536;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            slew_reg      <= '0;
            window_reg    <= 7'd10;
            ticks_reg     <= 16'd3574;
            left_rev_reg  <= 1'b1;
            right_rev_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_GAIN_P:        gain_p_reg    <= wr_data;
                REG_GAIN_I:        gain_i_reg    <= wr_data;
                REG_GAIN_D:        gain_d_reg    <= wr_data;
                REG_SLEW_LIMIT:    slew_reg      <= wr_data[16:0];
                REG_WINDOW:        window_reg    <= wr_data[6:0];
                REG_TICKS:         ticks_reg     <= wr_data[15:0];
                REG_LEFT_REVERSE:  left_rev_reg  <= wr_data[0];
                REG_RIGHT_REVERSE: right_rev_reg <= wr_data[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (window_reg == '0)
            n_wide = 32'd1;
        else if (32'(window_reg) > 32'(MAX_WINDOW))
            n_wide = 32'(MAX_WINDOW);
        else
            n_wide = 32'(window_reg);
        n_eff = N_W'(n_wide);

        accept  = in_ch.valid && in_ch.ready;
        win_end = (32'(idx_reg) + 32'd1) >= 32'(n_eff);
        merge   = done_l_reg && done_r_reg && (!out_valid_reg || out_ch.ready);

        sum_l_next = sum_l_reg - SUM_W'(in_ch.count_left);
        sum_r_next = sum_r_reg + SUM_W'(in_ch.count_right);

        cfg.gain_p = gain_p_reg;
        cfg.gain_i = gain_i_reg;
        cfg.gain_d = gain_d_reg;
        cfg.slew   = slew_reg;
        cfg.n      = DIVR_W'(n_eff);
        cfg.ticks  = (ticks_reg == '0) ? 16'd1 : ticks_reg;

        cmd_l.go      = go_reg;
        cmd_l.clear   = clear_pend_reg;
        cmd_l.reverse = left_rev_reg;
        cmd_l.tvel    = tvel_l_reg;
        cmd_l.tacc    = tacc_l_reg;
        cmd_r.go      = go_reg;
        cmd_r.clear   = clear_pend_reg;
        cmd_r.reverse = right_rev_reg;
        cmd_r.tvel    = tvel_r_reg;
        cmd_r.tacc    = tacc_r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_l_reg      <= '0;
            sum_r_reg      <= '0;
            idx_reg        <= '0;
            clear_pend_reg <= 1'b0;
            busy_reg       <= 1'b0;
            go_reg         <= 1'b0;
            done_l_reg     <= 1'b0;
            done_r_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            go_reg <= 1'b0;
            if (accept)
            begin
                sum_l_reg <= sum_l_next;
                sum_r_reg <= sum_r_next;
                if (in_ch.clear_terms)
                    clear_pend_reg <= 1'b1;
                if (win_end)
                begin
                    busy_reg <= 1'b1;
                    go_reg   <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (go_reg)
            begin
                sum_l_reg      <= '0;
                sum_r_reg      <= '0;
                idx_reg        <= '0;
                clear_pend_reg <= 1'b0;
            end
            if (res_l.done)
                done_l_reg <= 1'b1;
            if (res_r.done)
                done_r_reg <= 1'b1;
            if (merge)
            begin
                done_l_reg    <= 1'b0;
                done_r_reg    <= 1'b0;
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && win_end)
        begin
            tvel_l_reg <= in_ch.target_vel_left;
            tvel_r_reg <= in_ch.target_vel_right;
            tacc_l_reg <= in_ch.target_acc_left;
            tacc_r_reg <= in_ch.target_acc_right;
        end
        if (merge)
        begin
            drive_l_reg <= res_l.drive;
            drive_r_reg <= res_r.drive;
            angle_l_reg <= res_l.angle;
            angle_r_reg <= res_r.angle;
            speed_l_reg <= res_l.speed;
            speed_r_reg <= res_r.speed;
        end
    end

    dwv_lane #(.SUM_W(SUM_W)) u_lane_left (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_l),
        .cfg   (cfg),
        .sum   (sum_l_reg),
        .res   (res_l)
    );

    dwv_lane #(.SUM_W(SUM_W)) u_lane_right (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_r),
        .cfg   (cfg),
        .sum   (sum_r_reg),
        .res   (res_r)
    );

    assign in_ch.ready        = !busy_reg;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.drive_left  = drive_l_reg;
    assign out_ch.drive_right = drive_r_reg;
    assign out_ch.angle_left  = angle_l_reg;
    assign out_ch.angle_right = angle_r_reg;
    assign out_ch.speed_left  = speed_l_reg;
    assign out_ch.speed_right = speed_r_reg;

endmodule

### rtl/dwv_checker.sv
// ---------------------------------------------------------------------------
// Dual wheel velocity PID port checker
// Port level checks on result handshake and result ranges.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dwv_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [17:0] drive_left,
    input logic signed [17:0] drive_right,
    input logic [18:0]        angle_left,
    input logic [18:0]        angle_right
);
    import dwv_pkg::*;

    logic drive_ok;
    logic angle_ok;

    assign drive_ok = drive_left <= ONE_FX && drive_left >= -ONE_FX
                      && drive_right <= ONE_FX && drive_right >= -ONE_FX;
    assign angle_ok = angle_left < TWO_PI_FX && angle_right < TWO_PI_FX;

    `DWV_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
    `DWV_ASSERT(a_drive_range, clk, rst_n, out_valid |-> drive_ok)
    `DWV_ASSERT(a_angle_range, clk, rst_n, out_valid |-> angle_ok)
    `DWV_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !out_valid)

endmodule

bind dual_wheel_velocity_pid_top dwv_checker u_dwv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .drive_left  (out_ch.drive_left),
    .drive_right (out_ch.drive_right),
    .angle_left  (out_ch.angle_left),
    .angle_right (out_ch.angle_right)
);

### tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// Dual wheel velocity PID testbench
// Drives encoder items with bursty timing, stalls the result side, and
// compares each result against an in-bench controller prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import dwv_pkg::*;

    typedef struct {
        logic signed [31:0] count_left;
        logic signed [31:0] count_right;
        logic signed [31:0] tgt_vel_l;
        logic signed [31:0] tgt_vel_r;
        logic signed [31:0] acc_left;
        logic signed [31:0] acc_right;
        logic               clear;
    } encoder_item_t;

    typedef struct {
        logic signed [17:0] drive_left;
        logic signed [17:0] drive_right;
        logic [18:0]        angle_left;
        logic [18:0]        angle_right;
        logic signed [31:0] speed_left;
        logic signed [31:0] speed_right;
    } control_result_t;

    localparam longint TWO_PI_Q = 411775;
    localparam longint PI_Q     = 205887;
    localparam longint UNITY_Q  = 65536;
    localparam longint RATE_Q   = 500;
    localparam int     SETTLE   = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  wr_index;
    logic [REG_DATA_W-1:0] wr_data;

    dwv_in_if  in_ch ();
    dwv_out_if out_ch ();

    dual_wheel_velocity_pid_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // controller copy: registers
    logic signed [23:0] kp_q;
    logic signed [23:0] ki_q;
    logic signed [23:0] kd_q;
    logic [16:0]        slew_q;
    logic [6:0]         window_q;
    logic [15:0]        ticks_q;
    bit                 rev_left_q;
    bit                 rev_right_q;

    // controller copy: state
    longint win_sum [2];
    int     samples_taken;
    longint last_angle [2];
    longint last_speed [2];
    longint err_integral [2];
    longint last_drive [2];
    bit     clear_latched;

    encoder_item_t   pending_items [$];
    control_result_t expected_results [$];

    int errors;
    int items_sent;
    int results_checked;
    int burst_left;
    int gap_left;
    logic [15:0] stall_bits;
    int stall_phase;
    bit hold_req;
    bit hold_used;
    int hold_left;
    longint walk_l;
    longint walk_r;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic void run_lane(int w, longint n, longint ticks, longint tvel,
                                     longint tacc, bit rev, output longint drv,
                                     output longint ang, output longint spd);
        longint avg;
        longint diff;
        longint acc;
        longint err;
        longint derr;
        longint total;
        longint duty;
        longint slew;
        avg = (win_sum[w] / n) % ticks;
        if (avg < 0)
            avg += ticks;
        ang = (avg * TWO_PI_Q) / ticks;
        diff = ang - last_angle[w];
        if (diff < -PI_Q)
            diff += TWO_PI_Q;
        else if (diff > PI_Q)
            diff -= TWO_PI_Q;
        spd = clamp32(diff * RATE_Q / n);
        acc = clamp32((spd - last_speed[w]) * RATE_Q / n);
        err = clamp32(tvel - spd);
        derr = clamp32(tacc - acc);
        if (clear_latched)
            err_integral[w] = 0;
        err_integral[w] = clamp32(err_integral[w] + err);
        total = longint'(kp_q) * err + longint'(ki_q) * err_integral[w]
              + longint'(kd_q) * derr;
        duty = total >>> FRAC_BITS;
        if (duty > UNITY_Q)
            duty = UNITY_Q;
        else if (duty < -UNITY_Q)
            duty = -UNITY_Q;
        if (rev)
            duty = -duty;
        slew = longint'(slew_q);
        if (duty - last_drive[w] > slew)
            duty = last_drive[w] + slew;
        else if (duty - last_drive[w] < -slew)
            duty = last_drive[w] - slew;
        last_drive[w] = duty;
        last_angle[w] = ang;
        last_speed[w] = spd;
        drv = duty;
    endfunction

    function automatic void accumulate_sample(encoder_item_t it);
        longint n;
        longint ticks;
        longint d0, d1, a0, a1, s0, s1;
        control_result_t r;
        n = longint'(window_q);
        if (n < 1)
            n = 1;
        if (n > MAX_WINDOW_DEF)
            n = MAX_WINDOW_DEF;
        ticks = (ticks_q == 16'd0) ? 1 : longint'(ticks_q);
        win_sum[0] -= longint'(it.count_left);
        win_sum[1] += longint'(it.count_right);
        if (it.clear)
            clear_latched = 1'b1;
        samples_taken++;
        if (samples_taken < n)
            return;
        run_lane(0, n, ticks, it.tgt_vel_l, it.acc_left, rev_left_q, d0, a0, s0);
        run_lane(1, n, ticks, it.tgt_vel_r, it.acc_right, rev_right_q, d1, a1, s1);
        clear_latched = 1'b0;
        win_sum[0] = 0;
        win_sum[1] = 0;
        samples_taken = 0;
        r.drive_left  = 18'(d0);
        r.drive_right = 18'(d1);
        r.angle_left  = 19'(a0);
        r.angle_right = 19'(a1);
        r.speed_left  = 32'(s0);
        r.speed_right = 32'(s1);
        expected_results.push_back(r);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d, expected %0d (result %0d)",
                 what, got, want, results_checked);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [23:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            REG_GAIN_P:        kp_q = val;
            REG_GAIN_I:        ki_q = val;
            REG_GAIN_D:        kd_q = val;
            REG_SLEW_LIMIT:    slew_q = val[16:0];
            REG_WINDOW:        window_q = val[6:0];
            REG_TICKS:         ticks_q = val[15:0];
            REG_LEFT_REVERSE:  rev_left_q = val[0];
            REG_RIGHT_REVERSE: rev_right_q = val[0];
            default: ;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic queue_item(logic signed [31:0] cl, logic signed [31:0] cr,
                              logic signed [31:0] vl, logic signed [31:0] vr,
                              logic signed [31:0] al, logic signed [31:0] ar, logic clr);
        encoder_item_t it;
        it = '{cl, cr, vl, vr, al, ar, clr};
        pending_items.push_back(it);
    endtask

    function automatic logic signed [31:0] pick_target();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 2621440)) - 32'sd1310720;
        endcase
    endfunction

    task automatic queue_random(int count);
        int noisy;
        for (int k = 0; k < count; k++)
        begin
            noisy = ($urandom_range(0, 9) == 0);
            if (noisy)
                queue_item($urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom(), $urandom_range(0, 1));
            else
            begin
                walk_l += $signed($urandom_range(0, 600)) - 300;
                walk_r += $signed($urandom_range(0, 600)) - 300;
                queue_item(32'(walk_l), 32'(walk_r), pick_target(), pick_target(),
                           pick_target(), pick_target(), $urandom_range(0, 19) == 0);
            end
        end
    endtask

    function automatic logic [23:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 24'h000000;
            1:       return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            2:       return $urandom();
            default: return 24'($signed($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    function automatic logic [23:0] pick_window();
        case ($urandom_range(0, 19))
            0:       return 24'd64;
            1:       return 24'd0;
            2:       return 24'd127;
            3:       return $urandom_range(5, 20);
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    function automatic logic [23:0] pick_ticks();
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return 24'd1;
            2:       return 24'd65535;
            3:       return 24'd3574;
            default: return $urandom_range(2, 65535);
        endcase
    endfunction

    // clock-edge driver: bursts of items separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
        end
        else if (in_ch.valid && !in_ch.ready)
        begin
            // hold
        end
        else if (gap_left > 0)
        begin
            in_ch.valid <= 1'b0;
            gap_left    <= gap_left - 1;
        end
        else if (pending_items.size() != 0)
        begin
            encoder_item_t it;
            it = pending_items.pop_front();
            in_ch.valid            <= 1'b1;
            in_ch.count_left       <= it.count_left;
            in_ch.count_right      <= it.count_right;
            in_ch.target_vel_left  <= it.tgt_vel_l;
            in_ch.target_vel_right <= it.tgt_vel_r;
            in_ch.target_acc_left  <= it.acc_left;
            in_ch.target_acc_right <= it.acc_right;
            in_ch.clear_terms      <= it.clear;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 40);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            else
                burst_left <= burst_left - 1;
        end
        else
            in_ch.valid <= 1'b0;
    end

    // predict at acceptance
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            encoder_item_t it;
            it = '{in_ch.count_left, in_ch.count_right, in_ch.target_vel_left,
                   in_ch.target_vel_right, in_ch.target_acc_left, in_ch.target_acc_right,
                   in_ch.clear_terms};
            items_sent++;
            accumulate_sample(it);
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_req && !hold_used)
        begin
            hold_left <= 3000;
            hold_used <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // receiver stall pattern and result checking
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_bits   <= 16'hffff;
            stall_phase  <= 0;
        end
        else
        begin
            if (stall_phase == 255)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_bits <= 16'hffff;
                    1:       stall_bits <= 16'h0101;
                    default: stall_bits <= $urandom();
                endcase
            end
            stall_phase  <= (stall_phase + 1) % 256;
            out_ch.ready <= (hold_left == 0) && stall_bits[stall_phase % 16];
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result count", 1, 0);
                end
                else
                begin
                    control_result_t e;
                    e = expected_results.pop_front();
                    if (out_ch.drive_left !== e.drive_left)
                        report_mismatch("drive_left", out_ch.drive_left, e.drive_left);
                    if (out_ch.drive_right !== e.drive_right)
                        report_mismatch("drive_right", out_ch.drive_right, e.drive_right);
                    if (out_ch.angle_left !== e.angle_left)
                        report_mismatch("angle_left", out_ch.angle_left, e.angle_left);
                    if (out_ch.angle_right !== e.angle_right)
                        report_mismatch("angle_right", out_ch.angle_right, e.angle_right);
                    if (out_ch.speed_left !== e.speed_left)
                        report_mismatch("speed_left", out_ch.speed_left, e.speed_left);
                    if (out_ch.speed_right !== e.speed_right)
                        report_mismatch("speed_right", out_ch.speed_right, e.speed_right);
                    results_checked++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d results pending", expected_results.size());
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        hold_req = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.count_left = '0;
        in_ch.count_right = '0;
        in_ch.target_vel_left = '0;
        in_ch.target_vel_right = '0;
        in_ch.target_acc_left = '0;
        in_ch.target_acc_right = '0;
        in_ch.clear_terms = 1'b0;
        out_ch.ready = 1'b0;
        errors = 0;
        items_sent = 0;
        results_checked = 0;
        walk_l = 0;
        walk_r = 0;
        kp_q = 24'sd65536;
        ki_q = '0;
        kd_q = '0;
        slew_q = '0;
        window_q = 7'd10;
        ticks_q = 16'd3574;
        rev_left_q = 1'b1;
        rev_right_q = 1'b0;
        win_sum = '{0, 0};
        samples_taken = 0;
        last_angle = '{0, 0};
        last_speed = '{0, 0};
        err_integral = '{0, 0};
        last_drive = '{0, 0};
        clear_latched = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // default registers, one window
        for (int k = 0; k < 10; k++)
            queue_item(32'sd100 * k, -32'sd37 * k, 32'sd65536, -32'sd65536, 0, 0, 1'b0);
        wait_idle();

        // extremes with single-sample windows
        write_reg(REG_WINDOW, 24'd1);
        write_reg(REG_TICKS, 24'd0);
        write_reg(REG_GAIN_P, 24'h7fffff);
        write_reg(REG_GAIN_I, 24'h800000);
        write_reg(REG_GAIN_D, 24'h7fffff);
        write_reg(REG_SLEW_LIMIT, 24'd65536);
        write_reg(REG_LEFT_REVERSE, 24'd0);
        write_reg(REG_RIGHT_REVERSE, 24'd1);
        queue_item(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                   32'sh80000000, 32'sh7fffffff, 1'b0);
        queue_item(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                   32'sh7fffffff, 32'sh80000000, 1'b1);
        wait_idle();
        write_reg(REG_TICKS, 24'd65535);
        write_reg(REG_SLEW_LIMIT, 24'd0);
        queue_item(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                   32'sh7fffffff, 32'sh7fffffff, 1'b0);
        queue_item(-32'sd1, 32'sd1, 0, 0, 0, 0, 1'b0);
        wait_idle();
        write_reg(REG_SLEW_LIMIT, 24'h01ffff);
        write_reg(REG_TICKS, 24'd1);
        write_reg(REG_WINDOW, 24'd0);
        queue_item(32'sd5, 32'sd5, 32'sd1000, 32'sd1000, 0, 0, 1'b1);
        wait_idle();

        // window shortened mid-window, clear latched early in the window
        write_reg(REG_TICKS, 24'd3574);
        write_reg(REG_WINDOW, 24'd4);
        write_reg(REG_GAIN_P, 24'd65536);
        write_reg(REG_GAIN_I, 24'd32768);
        queue_item(32'sd1500, 32'sd900, 32'sd200000, 32'sd200000, 0, 0, 1'b1);
        queue_item(32'sd1600, 32'sd950, 32'sd200000, 32'sd200000, 0, 0, 1'b0);
        queue_item(32'sd1700, 32'sd1000, 32'sd200000, 32'sd200000, 0, 0, 1'b0);
        wait_idle();
        write_reg(REG_WINDOW, 24'd2);
        queue_item(32'sd1800, 32'sd1050, -32'sd200000, 32'sd200000, 0, 0, 1'b0);
        queue_item(32'sd1900, 32'sd1100, -32'sd200000, 32'sd200000, 0, 0, 1'b0);
        wait_idle();

        // random phases with fresh settings
        for (int phase = 0; phase < 12; phase++)
        begin
            write_reg(REG_GAIN_P, pick_gain());
            write_reg(REG_GAIN_I, pick_gain());
            write_reg(REG_GAIN_D, pick_gain());
            case ($urandom_range(0, 3))
                0:       write_reg(REG_SLEW_LIMIT, 24'd0);
                1:       write_reg(REG_SLEW_LIMIT, 24'd65536);
                default: write_reg(REG_SLEW_LIMIT, $urandom_range(0, 131071));
            endcase
            write_reg(REG_WINDOW, (phase == 3) ? 24'd1 : pick_window());
            write_reg(REG_TICKS, pick_ticks());
            write_reg(REG_LEFT_REVERSE, $urandom_range(0, 1));
            write_reg(REG_RIGHT_REVERSE, $urandom_range(0, 1));
            if (phase == 3)
                hold_req <= 1'b1;
            queue_random(105);
            wait_idle();
        end

        $display("covered %0d encoder items and %0d control windows", items_sent,
                 results_checked);
        $display("register sweeps over gains, slew, window length and revolution size");
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/dwv_pkg.sv
rtl/dwv_ifs.sv
rtl/dwv_div.sv
rtl/dwv_lane.sv
rtl/dual_wheel_velocity_pid_top.sv
rtl/dwv_checker.sv
tb/sv/testbench.sv
